/* hdl/cksb_pkg.sv */
`timescale 1ns / 1ps

package cksb_pkg;

    localparam int C_PIXEL_W    = 8;
    localparam int C_ADDR_W     = 20;
    localparam int C_CFG_IDX_W  = 4;
    localparam int C_CFG_DATA_W = 11;
    localparam int C_SCREEN_W   = 11;
    localparam int C_ORIGIN_W   = 10;
    localparam int C_MODE_W     = 2;

    localparam logic [C_CFG_IDX_W-1:0] C_REG_SCREEN_WIDTH  = 4'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_SCREEN_HEIGHT = 4'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_ORIGIN_X      = 4'd2;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_ORIGIN_Y      = 4'd3;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_RECT_WIDTH    = 4'd4;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_RECT_HEIGHT   = 4'd5;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_BLIT_MODE     = 4'd6;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_FILL_COLOR    = 4'd7;

    localparam logic [C_MODE_W-1:0] C_MODE_COPY    = 2'd0;
    localparam logic [C_MODE_W-1:0] C_MODE_FILL    = 2'd1;
    localparam logic [C_MODE_W-1:0] C_MODE_STENCIL = 2'd2;

    typedef struct packed {
        logic                 write_enable;
        logic [C_ADDR_W-1:0]  row_base;
        logic [C_ADDR_W-1:0]  col_offset;
        logic [C_PIXEL_W-1:0] write_data;
        logic                 off_screen;
        logic                 last;
        logic                 blit_error;
    } t_item;

    typedef struct packed {
        logic                 write_enable;
        logic [C_ADDR_W-1:0]  write_address;
        logic [C_PIXEL_W-1:0] write_data;
        logic                 off_screen;
        logic                 last;
        logic                 blit_error;
    } t_result;

endpackage

/* hdl/cksb_front.sv */
`timescale 1ns / 1ps

module cksb_front #(
    parameter int unsigned MAX_DIM         = 1024,
    parameter int unsigned TRANSPARENT_KEY = 255
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [cksb_pkg::C_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cksb_pkg::C_CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                i_accept,
    input  logic [cksb_pkg::C_PIXEL_W-1:0]      i_pixel,
    output cksb_pkg::t_item                     o_item
);
    import cksb_pkg::*;

    localparam int CW   = $clog2(MAX_DIM);
    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int EW   = (DW > C_CFG_DATA_W) ? DW : C_CFG_DATA_W;
    localparam int SXW  = ((CW > C_ORIGIN_W) ? CW : C_ORIGIN_W) + 1;
    localparam int CMPW = (SXW > C_SCREEN_W) ? SXW : C_SCREEN_W;
    localparam logic [C_PIXEL_W-1:0] KEY = C_PIXEL_W'(TRANSPARENT_KEY);

    logic [C_SCREEN_W-1:0] r_screen_w, r_screen_h;
    logic [C_ORIGIN_W-1:0] r_origin_x, r_origin_y;
    logic [CW-1:0]         r_w_last, r_h_last;
    logic [C_MODE_W-1:0]   r_mode;
    logic [C_PIXEL_W-1:0]  r_fill;
    logic [CW-1:0]         r_col, r_row;
    logic [C_ADDR_W-1:0]   r_row_base, r_origin_base;
    logic                  r_err;

    logic [C_SCREEN_W-1:0]              n_screen_w;
    logic [C_ORIGIN_W-1:0]              n_origin_y;
    logic [C_SCREEN_W+C_ORIGIN_W-1:0]   cfg_product;
    logic [EW-1:0]                      cfg_ext;
    logic [CW-1:0]                      cfg_dim_last;
    logic                               cfg_hit;

    logic [SXW-1:0]        sx, sy;
    logic                  off, reject, want, we, set_err, first, col_end, row_end;
    logic [C_PIXEL_W-1:0]  data;

    always_comb begin
        cfg_hit    = i_cfg_valid && (i_cfg_index <= C_REG_FILL_COLOR);
        n_screen_w = (i_cfg_index == C_REG_SCREEN_WIDTH) ? i_cfg_data : r_screen_w;
        n_origin_y = (i_cfg_index == C_REG_ORIGIN_Y) ? i_cfg_data[C_ORIGIN_W-1:0]
                                                     : r_origin_y;
        cfg_product = (C_SCREEN_W+C_ORIGIN_W)'(n_screen_w)
                    * (C_SCREEN_W+C_ORIGIN_W)'(n_origin_y);
        cfg_ext = EW'(i_cfg_data);
        if (cfg_ext == '0) begin
            cfg_dim_last = '0;
        end else if (cfg_ext > EW'(MAX_DIM)) begin
            cfg_dim_last = CW'(MAX_DIM - 1);
        end else begin
            cfg_dim_last = CW'(cfg_ext - EW'(1));
        end
    end

    always_comb begin
        first   = (r_col == '0) && (r_row == '0);
        col_end = (r_col == r_w_last);
        row_end = (r_row == r_h_last);
        sx      = SXW'(r_origin_x) + SXW'(r_col);
        sy      = SXW'(r_origin_y) + SXW'(r_row);
        off     = (CMPW'(sx) >= CMPW'(r_screen_w)) || (CMPW'(sy) >= CMPW'(r_screen_h));
        reject  = (CMPW'(r_origin_x) >= CMPW'(r_screen_w))
               || (CMPW'(r_origin_y) >= CMPW'(r_screen_h));
        unique case (r_mode)
            C_MODE_COPY: begin
                want = (i_pixel != KEY);
                data = i_pixel;
            end
            C_MODE_FILL: begin
                want = (r_fill != KEY);
                data = r_fill;
            end
            C_MODE_STENCIL: begin
                want = (i_pixel == '0) && (r_fill != KEY);
                data = r_fill;
            end
            default: begin
                want = 1'b0;
                data = '0;
            end
        endcase
        we      = !reject && want && !off;
        set_err = reject || (want && off);

        o_item.write_enable = we;
        o_item.row_base     = r_row_base;
        o_item.col_offset   = C_ADDR_W'(sx);
        o_item.write_data   = we ? data : '0;
        o_item.off_screen   = off;
        o_item.last         = col_end && row_end;
        o_item.blit_error   = (!first && r_err) || set_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w    <= C_SCREEN_W'(1024);
            r_screen_h    <= C_SCREEN_W'(768);
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_w_last      <= '0;
            r_h_last      <= '0;
            r_mode        <= C_MODE_COPY;
            r_fill        <= '0;
            r_col         <= '0;
            r_row         <= '0;
            r_row_base    <= '0;
            r_origin_base <= '0;
            r_err         <= 1'b0;
        end else if (cfg_hit) begin
            unique case (i_cfg_index)
                C_REG_SCREEN_WIDTH:  r_screen_w <= i_cfg_data;
                C_REG_SCREEN_HEIGHT: r_screen_h <= i_cfg_data;
                C_REG_ORIGIN_X:      r_origin_x <= i_cfg_data[C_ORIGIN_W-1:0];
                C_REG_ORIGIN_Y:      r_origin_y <= i_cfg_data[C_ORIGIN_W-1:0];
                C_REG_RECT_WIDTH:    r_w_last   <= cfg_dim_last;
                C_REG_RECT_HEIGHT:   r_h_last   <= cfg_dim_last;
                C_REG_BLIT_MODE:     r_mode     <= i_cfg_data[C_MODE_W-1:0];
                default:             r_fill     <= i_cfg_data[C_PIXEL_W-1:0];
            endcase
            // restart the blit
            r_col         <= '0;
            r_row         <= '0;
            r_row_base    <= cfg_product[C_ADDR_W-1:0];
            r_origin_base <= cfg_product[C_ADDR_W-1:0];
            r_err         <= 1'b0;
        end else if (i_accept) begin
            r_err <= o_item.blit_error;
            if (col_end) begin
                r_col <= '0;
                if (row_end) begin
                    r_row      <= '0;
                    r_row_base <= r_origin_base;
                end else begin
                    r_row      <= r_row + CW'(1);
                    r_row_base <= r_row_base + C_ADDR_W'(r_screen_w);
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

endmodule

/* hdl/cksb_queue.sv */
`timescale 1ns / 1ps

module cksb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cksb_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output cksb_pkg::t_item o_item
);
    import cksb_pkg::*;

    t_item       r_mem [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;
    logic        do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/cksb_back.sv */
`timescale 1ns / 1ps

module cksb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  cksb_pkg::t_item   i_item,
    output logic              o_take,
    input  logic              i_pop,
    output logic              o_empty,
    output cksb_pkg::t_result o_result
);
    import cksb_pkg::*;

    t_result r_out;
    logic    r_out_valid;
    t_result n_out;

    assign o_take   = i_avail && (!r_out_valid || i_pop);
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_out.write_enable  = i_item.write_enable;
        n_out.write_address = i_item.write_enable ? (i_item.row_base + i_item.col_offset)
                                                  : '0;
        n_out.write_data    = i_item.write_data;
        n_out.off_screen    = i_item.off_screen;
        n_out.last          = i_item.last;
        n_out.blit_error    = i_item.blit_error;
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

/* hdl/color_keyed_sprite_blitter_top.sv */
`timescale 1ns / 1ps

// Colour-keyed sprite blitter for an 8-bit-per-pixel frame buffer. Push one sprite pixel per
// transaction in row-major order; each gives exactly one result transaction carrying the
// frame buffer write (or no write), the off-screen flag, the last-pixel marker and the sticky
// blit error. Throughput is one pixel per clock while full is low; a pixel's result reaches
// the result ports through a combinational classify stage, a two-entry queue and a
// registered address adder; a stalled result fills the queue and then raises full.
// Writes to indexes 0-7 restart the blit; write registers only while no result is pending.
// The register write channel is always ready and its effect is visible on the next cycle.
module color_keyed_sprite_blitter_top #(
    parameter int unsigned MAX_DIM         = 1024,
    parameter int unsigned TRANSPARENT_KEY = 255
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [cksb_pkg::C_PIXEL_W-1:0]      i_pixel,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_write_enable,
    output logic [cksb_pkg::C_ADDR_W-1:0]       o_write_address,
    output logic [cksb_pkg::C_PIXEL_W-1:0]      o_write_data,
    output logic                                o_off_screen,
    output logic                                o_last,
    output logic                                o_blit_error,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cksb_pkg::C_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cksb_pkg::C_CFG_DATA_W-1:0]   i_cfg_data
);
    import cksb_pkg::*;

    t_item   front_item, queue_item;
    t_result result;
    logic    accept, queue_empty, take;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    cksb_front #(
        .MAX_DIM         (MAX_DIM),
        .TRANSPARENT_KEY (TRANSPARENT_KEY)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pixel     (i_pixel),
        .o_item      (front_item)
    );

    cksb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (take),
        .o_empty (queue_empty),
        .o_item  (queue_item)
    );

    cksb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (!queue_empty),
        .i_item   (queue_item),
        .o_take   (take),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (result)
    );

    assign o_write_enable  = result.write_enable;
    assign o_write_address = result.write_address;
    assign o_write_data    = result.write_data;
    assign o_off_screen    = result.off_screen;
    assign o_last          = result.last;
    assign o_blit_error    = result.blit_error;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import cksb_pkg::*;

    localparam int unsigned MAX_SIZE = 1024;
    localparam logic [C_PIXEL_W-1:0] KEY_COLOUR = 8'hFF;
    localparam logic [C_MODE_W-1:0] C_MODE_NONE = 2'd3;
    localparam logic [C_CFG_IDX_W-1:0] REG_UNUSED_FIRST = 4'd8;
    localparam logic [C_CFG_IDX_W-1:0] REG_UNUSED_LAST = 4'd15;
    localparam int PIPE_LATENCY = 2;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic [C_PIXEL_W-1:0]    i_pixel = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic                    o_write_enable;
    logic [C_ADDR_W-1:0]     o_write_address;
    logic [C_PIXEL_W-1:0]    o_write_data;
    logic                    o_off_screen;
    logic                    o_last;
    logic                    o_blit_error;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [C_CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [C_CFG_DATA_W-1:0] i_cfg_data = '0;

    color_keyed_sprite_blitter_top #(
        .MAX_DIM         (MAX_SIZE),
        .TRANSPARENT_KEY (KEY_COLOUR)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_pixel         (i_pixel),
        .empty           (empty),
        .pop             (pop),
        .o_write_enable  (o_write_enable),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_off_screen    (o_off_screen),
        .o_last          (o_last),
        .o_blit_error    (o_blit_error),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [10:0]         scr_w = 11'd1024;
    logic [10:0]         scr_h = 11'd768;
    logic [9:0]          org_x = '0;
    logic [9:0]          org_y = '0;
    logic [10:0]         rect_w = 11'd1;
    logic [10:0]         rect_h = 11'd1;
    logic [C_MODE_W-1:0] mode = C_MODE_COPY;
    logic [7:0]          fill = '0;
    int unsigned         col_cnt = 0;
    int unsigned         row_cnt = 0;
    logic [19:0]         row_base = '0;
    logic                blit_err = 1'b0;

    t_result     expected_writes[$];
    t_result     seen;
    t_result     wanted;
    int          mismatches = 0;
    int          burst_left = 0;
    int          pop_mode = 0;
    int          pop_left = 0;

    function automatic int unsigned dim_of(input logic [10:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIZE) return MAX_SIZE;
        return v;
    endfunction

    function automatic logic [19:0] origin_row_base();
        int unsigned prod;
        prod = org_y * scr_w;
        return prod[19:0];
    endfunction

    function automatic void apply_register(input logic [C_CFG_IDX_W-1:0] idx,
                                           input logic [C_CFG_DATA_W-1:0] value);
        case (idx)
            C_REG_SCREEN_WIDTH:  scr_w = value;
            C_REG_SCREEN_HEIGHT: scr_h = value;
            C_REG_ORIGIN_X:      org_x = value[9:0];
            C_REG_ORIGIN_Y:      org_y = value[9:0];
            C_REG_RECT_WIDTH:    rect_w = value;
            C_REG_RECT_HEIGHT:   rect_h = value;
            C_REG_BLIT_MODE:     mode = value[1:0];
            C_REG_FILL_COLOR:    fill = value[7:0];
            default:             return;
        endcase
        col_cnt = 0;
        row_cnt = 0;
        row_base = origin_row_base();
        blit_err = 1'b0;
    endfunction

    function automatic t_result blit_pixel(input logic [7:0] px);
        int unsigned w, h, sx, sy, sum;
        logic        off, reject, want, we, last_px;
        logic [7:0]  data;
        logic [19:0] addr;
        w = dim_of(rect_w);
        h = dim_of(rect_h);
        if (col_cnt == 0 && row_cnt == 0) blit_err = 1'b0;
        sx = org_x + col_cnt;
        sy = org_y + row_cnt;
        off = (sx >= scr_w) || (sy >= scr_h);
        reject = (org_x >= scr_w) || (org_y >= scr_h);
        want = 1'b0;
        we = 1'b0;
        data = '0;
        addr = '0;
        case (mode)
            C_MODE_COPY: begin
                want = px != KEY_COLOUR;
                data = px;
            end
            C_MODE_FILL: begin
                want = fill != KEY_COLOUR;
                data = fill;
            end
            C_MODE_STENCIL: begin
                want = (px == 0) && (fill != KEY_COLOUR);
                data = fill;
            end
            default: want = 1'b0;
        endcase
        if (reject) begin
            blit_err = 1'b1;
        end else if (want) begin
            if (off) begin
                blit_err = 1'b1;
            end else begin
                we = 1'b1;
                sum = row_base + sx;
                addr = sum[19:0];
            end
        end
        if (!we) data = '0;
        last_px = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            sum = row_base + scr_w;
            row_base = sum[19:0];
            if (row_cnt >= h) begin
                row_cnt = 0;
                row_base = origin_row_base();
            end
        end
        return '{we, addr, data, off, last_px, blit_err};
    endfunction

    task automatic note_mismatch(input string what, input t_result want_r, input t_result got_r);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s at %0t: expected we=%0b addr=%05h data=%02h off=%0b last=%0b err=%0b",
                     what, $realtime, want_r.write_enable, want_r.write_address,
                     want_r.write_data, want_r.off_screen, want_r.last, want_r.blit_error);
            $display("    actual   we=%0b addr=%05h data=%02h off=%0b last=%0b err=%0b",
                     got_r.write_enable, got_r.write_address, got_r.write_data,
                     got_r.off_screen, got_r.last, got_r.blit_error);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                seen = '{o_write_enable, o_write_address, o_write_data,
                         o_off_screen, o_last, o_blit_error};
                if (expected_writes.size() == 0) begin
                    note_mismatch("unexpected transaction", '0, seen);
                end else begin
                    wanted = expected_writes.pop_front();
                    if (seen.write_enable !== wanted.write_enable ||
                        seen.write_address !== wanted.write_address ||
                        seen.write_data !== wanted.write_data ||
                        seen.off_screen !== wanted.off_screen ||
                        seen.last !== wanted.last ||
                        seen.blit_error !== wanted.blit_error)
                        note_mismatch("field mismatch", wanted, seen);
                end
            end
            if (i_cfg_valid && o_cfg_ready) apply_register(i_cfg_index, i_cfg_data);
            if (push && !full) expected_writes.push_back(blit_pixel(i_pixel));
        end
    end

    always @(posedge i_clk) begin
        if (pop_left == 0) begin
            pop_mode = $urandom_range(0, 3);
            pop_left = $urandom_range(8, 64);
        end
        pop_left--;
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= ($urandom_range(0, 7) == 0);
            default: pop <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic push_pixel(input logic [7:0] px);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0) begin
            push <= 1'b0;
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_pixel <= px;
        i_cfg_valid <= 1'b0;
        do @(posedge i_clk); while (full);
    endtask

    task automatic cfg_write(input logic [C_CFG_IDX_W-1:0] idx, input logic [10:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_writes.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_pixel();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return KEY_COLOUR;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic stream_pixels(input int n);
        for (int i = 0; i < n; i++) push_pixel(random_pixel());
    endtask

    function automatic logic [10:0] pick_screen();
        case ($urandom_range(0, 9))
            0:       return 11'd0;
            1, 2, 3, 4, 5: return 11'($urandom_range(1, 40));
            6, 7:    return 11'($urandom_range(1, 1024));
            8:       return 11'd1024;
            default: return 11'($urandom_range(1025, 2047));
        endcase
    endfunction

    function automatic logic [10:0] pick_origin(input logic [10:0] lim);
        int v;
        case ($urandom_range(0, 3))
            0:       v = 0;
            1:       v = $urandom_range(0, (lim > 1022) ? 1023 : lim + 1);
            2:       v = int'(lim) + 1 - int'($urandom_range(0, 3));
            default: v = $urandom_range(0, 1023);
        endcase
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return {1'($urandom), 10'(v)};
    endfunction

    function automatic logic [10:0] pick_rect();
        if ($urandom_range(0, 9) == 0) return 11'($urandom_range(0, 20));
        return 11'($urandom_range(1, 6));
    endfunction

    function automatic logic [7:0] pick_colour();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return KEY_COLOUR;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_settings(output logic [10:0] rw, output logic [10:0] rh);
        logic [10:0] w_scr, h_scr;
        w_scr = scr_w;
        h_scr = scr_h;
        if ($urandom_range(0, 2) == 0) begin
            w_scr = pick_screen();
            cfg_write(C_REG_SCREEN_WIDTH, w_scr);
        end
        if ($urandom_range(0, 2) == 0) begin
            h_scr = pick_screen();
            cfg_write(C_REG_SCREEN_HEIGHT, h_scr);
        end
        if ($urandom_range(0, 1) == 0) cfg_write(C_REG_ORIGIN_X, pick_origin(w_scr));
        if ($urandom_range(0, 1) == 0) cfg_write(C_REG_ORIGIN_Y, pick_origin(h_scr));
        rw = pick_rect();
        rh = pick_rect();
        cfg_write(C_REG_RECT_WIDTH, rw);
        cfg_write(C_REG_RECT_HEIGHT, rh);
        if ($urandom_range(0, 2) == 0)
            cfg_write(C_REG_BLIT_MODE, {9'($urandom), 2'($urandom_range(0, 3))});
        if ($urandom_range(0, 2) == 0)
            cfg_write(C_REG_FILL_COLOR, {3'($urandom), pick_colour()});
        if ($urandom_range(0, 7) == 0)
            cfg_write(4'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), 11'($urandom));
    endtask

    task automatic test_copy_keying();
        push_pixel(8'h00);
        push_pixel(KEY_COLOUR);
        push_pixel(8'h01);
        push_pixel(8'hFE);
        wait_idle();
        cfg_write(C_REG_ORIGIN_X, 11'd1023);
        cfg_write(C_REG_ORIGIN_Y, 11'd767);
        cfg_write(C_REG_RECT_WIDTH, 11'd3);
        cfg_write(C_REG_RECT_HEIGHT, 11'd2);
        push_pixel(8'h5A);
        push_pixel(KEY_COLOUR);
        push_pixel(8'hA5);
        push_pixel(8'h00);
        push_pixel(KEY_COLOUR);
        push_pixel(8'h80);
    endtask

    task automatic test_fill_and_stencil();
        wait_idle();
        cfg_write(C_REG_ORIGIN_X, 11'd5);
        cfg_write(C_REG_ORIGIN_Y, 11'd5);
        cfg_write(C_REG_RECT_WIDTH, 11'd2);
        cfg_write(C_REG_RECT_HEIGHT, 11'd1);
        cfg_write(C_REG_BLIT_MODE, 11'(C_MODE_FILL));
        cfg_write(C_REG_FILL_COLOR, 11'd0);
        push_pixel(8'h33);
        push_pixel(KEY_COLOUR);
        wait_idle();
        cfg_write(C_REG_FILL_COLOR, 11'(KEY_COLOUR));
        push_pixel(8'h00);
        push_pixel(8'h44);
        wait_idle();
        cfg_write(C_REG_BLIT_MODE, 11'(C_MODE_STENCIL));
        cfg_write(C_REG_FILL_COLOR, 11'h73C);
        push_pixel(8'h00);
        push_pixel(8'h07);
        wait_idle();
        cfg_write(C_REG_BLIT_MODE, 11'(C_MODE_NONE));
        push_pixel(8'h00);
        push_pixel(8'h11);
    endtask

    task automatic test_rejected_origin();
        wait_idle();
        cfg_write(C_REG_BLIT_MODE, 11'(C_MODE_COPY));
        cfg_write(C_REG_SCREEN_WIDTH, 11'd16);
        cfg_write(C_REG_ORIGIN_X, 11'd16);
        cfg_write(C_REG_RECT_WIDTH, 11'd0);
        cfg_write(C_REG_RECT_HEIGHT, 11'd0);
        push_pixel(8'h12);
        wait_idle();
        cfg_write(C_REG_SCREEN_WIDTH, 11'd0);
        push_pixel(8'h34);
    endtask

    task automatic test_unused_index();
        wait_idle();
        cfg_write(C_REG_SCREEN_WIDTH, 11'd16);
        cfg_write(C_REG_SCREEN_HEIGHT, 11'd16);
        cfg_write(C_REG_ORIGIN_X, 11'd14);
        cfg_write(C_REG_ORIGIN_Y, 11'd0);
        cfg_write(C_REG_RECT_WIDTH, 11'd2);
        cfg_write(C_REG_RECT_HEIGHT, 11'd2);
        push_pixel(8'h21);
        push_pixel(8'h22);
        wait_idle();
        cfg_write(REG_UNUSED_FIRST, 11'h7FF);
        cfg_write(REG_UNUSED_LAST, 11'h000);
        push_pixel(8'h23);
        push_pixel(8'h24);
    endtask

    task automatic test_clamped_rect();
        wait_idle();
        cfg_write(C_REG_SCREEN_WIDTH, 11'd2047);
        cfg_write(C_REG_SCREEN_HEIGHT, 11'd2047);
        cfg_write(C_REG_ORIGIN_X, 11'd1000);
        cfg_write(C_REG_ORIGIN_Y, 11'd1023);
        cfg_write(C_REG_RECT_WIDTH, 11'd2047);
        cfg_write(C_REG_RECT_HEIGHT, 11'd0);
        stream_pixels(40);
        wait_idle();
        cfg_write(C_REG_ORIGIN_X, 11'd1023);
        cfg_write(C_REG_ORIGIN_Y, 11'd0);
        cfg_write(C_REG_RECT_WIDTH, 11'd1);
        cfg_write(C_REG_RECT_HEIGHT, 11'd1100);
        stream_pixels(40);
    endtask

    task automatic test_random_blits(input int target);
        int          sent;
        int unsigned area;
        int unsigned n;
        logic [10:0] rw, rh;
        sent = 0;
        while (sent < target) begin
            wait_idle();
            random_settings(rw, rh);
            area = dim_of(rw) * dim_of(rh);
            n = area * $urandom_range(1, 3);
            if ($urandom_range(0, 2) == 0) n += $urandom_range(1, area);
            stream_pixels(n);
            sent += n;
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_copy_keying();
        test_fill_and_stencil();
        test_rejected_origin();
        test_unused_index();
        test_clamped_rect();
        test_random_blits(800);
        wait_idle();
        if (mismatches == 0 && expected_writes.size() == 0)
            $display("color_keyed_sprite_blitter_top: match");
        else
            $display("color_keyed_sprite_blitter_top: mismatch");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("color_keyed_sprite_blitter_top: mismatch");
        $finish;
    end

endmodule

/* color_keyed_sprite_blitter_top.f */
hdl/cksb_pkg.sv
hdl/cksb_front.sv
hdl/cksb_queue.sv
hdl/cksb_back.sv
hdl/color_keyed_sprite_blitter_top.sv
verif/tb.sv
